>>> rtl/ptz_command_framer_tour_defines.svh
// assertion macros for the ptz command framer
`ifndef PTZ_COMMAND_FRAMER_TOUR_DEFINES_SVH
`define PTZ_COMMAND_FRAMER_TOUR_DEFINES_SVH
`ifndef SYNTHESIS
`define PTZ_ASSERT_IMPL(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
        else $error("assertion failed");
`define PTZ_ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");
`else
`define PTZ_ASSERT_IMPL(label, clk, rst_n, cond, res)
`define PTZ_ASSERT_NEXT(label, clk, rst_n, cond, res)
`endif
`endif

>>> rtl/ptz_pkg.sv
// ----------------------------------------------------------------------------
// ptz_pkg
// shared constants, types and the packet byte function of the framer
// ----------------------------------------------------------------------------
package ptz_pkg;
    localparam int TourDepthDef  = 16;
    localparam int QueueDepthDef = 16;

    localparam logic [4:0] C_TICK = 5'd0, C_REPLY = 5'd1, C_START = 5'd2,
        C_STOP = 5'd3, C_LUP = 5'd4, C_LDN = 5'd5, C_PSPD = 5'd6, C_PSET = 5'd7,
        C_PCALL = 5'd8, C_PANL = 5'd9, C_PANR = 5'd10, C_TUP = 5'd11,
        C_TDN = 5'd12, C_HOME = 5'd13, C_ZIN = 5'd14, C_ZOUT = 5'd15,
        C_FIN = 5'd16, C_FOUT = 5'd17, C_FSTOP = 5'd18, C_FMODE = 5'd19,
        C_ZSTOP = 5'd20, C_MSTOP = 5'd21, C_APPEND = 5'd22, C_REPL = 5'd23,
        C_REMOVE = 5'd24;

    // one queued command
    typedef struct packed {
        logic [7:0]  b;
        logic [7:0]  a;
        logic [4:0]  code;
        logic [15:0] seq;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic step;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic send;
        logic last;
    } t_sts;

    // payload length of a code
    function automatic logic [7:0] pay_len(input logic [4:0] code);
        logic [7:0] n;
        case (code)
            C_LUP: n = 8'd1;
            C_PSPD: n = 8'd8;
            C_PSET, C_PCALL: n = 8'd7;
            C_PANL, C_PANR, C_TUP, C_TDN, C_MSTOP: n = 8'd9;
            C_HOME: n = 8'd5;
            default: n = 8'd6;
        endcase
        return n;
    endfunction

    // byte at index i of the framed packet
    function automatic logic [7:0] pkt_byte(input t_entry e, input logic [4:0] i);
        logic [7:0] q;
        logic [3:0] k;
        k = 4'(i - 5'd8);
        q = 8'h00;
        if (i < 5'd8) begin
            case (i[2:0])
                3'd0: q = (e.code == C_LUP) ? 8'h02 : 8'h01;
                3'd3: q = pay_len(e.code);
                3'd6: q = e.seq[15:8];
                3'd7: q = e.seq[7:0];
                default: q = 8'h00;
            endcase
        end else if (k == 4'd0) begin
            q = (e.code == C_LUP) ? 8'h01 : 8'h81;
        end else if (k == 4'd1) begin
            q = 8'h01;
        end else begin
            case (e.code)
                C_PSPD: begin
                    case (k)
                        4'd2: q = 8'h7e; 4'd3: q = 8'h01; 4'd4: q = 8'h0b;
                        4'd5: q = e.a; 4'd6: q = e.b; default: q = 8'hff;
                    endcase
                end
                C_PSET, C_PCALL: begin
                    case (k)
                        4'd2: q = 8'h04; 4'd3: q = 8'h3f;
                        4'd4: q = (e.code == C_PSET) ? 8'h01 : 8'h02;
                        4'd5: q = e.a; default: q = 8'hff;
                    endcase
                end
                C_PANL, C_PANR, C_TUP, C_TDN, C_MSTOP: begin
                    case (k)
                        4'd2: q = 8'h06; 4'd3: q = 8'h01;
                        4'd4: q = (e.code == C_PANL || e.code == C_PANR) ? e.a : 8'h05;
                        4'd5: q = (e.code == C_TUP || e.code == C_TDN) ? e.a : 8'h05;
                        4'd6: q = (e.code == C_PANL) ? 8'h01 :
                                  (e.code == C_PANR) ? 8'h02 : 8'h03;
                        4'd7: q = (e.code == C_TUP) ? 8'h01 :
                                  (e.code == C_TDN) ? 8'h02 : 8'h03;
                        default: q = 8'hff;
                    endcase
                end
                C_HOME: begin
                    case (k)
                        4'd2: q = 8'h06; 4'd3: q = 8'h04; default: q = 8'hff;
                    endcase
                end
                default: begin
                    case (k)
                        4'd2: q = 8'h04;
                        4'd3: q = (e.code == C_FIN || e.code == C_FOUT ||
                                   e.code == C_FSTOP) ? 8'h08 :
                                  (e.code == C_FMODE) ? 8'h38 : 8'h07;
                        4'd4: begin
                            case (e.code)
                                C_ZIN, C_FOUT: q = 8'h20 + e.a;
                                C_ZOUT, C_FIN: q = 8'h30 + e.a;
                                C_FMODE: q = (e.a != 8'h00) ? 8'h02 : 8'h03;
                                default: q = 8'h00;
                            endcase
                        end
                        default: q = 8'hff;
                    endcase
                end
            endcase
        end
        return q;
    endfunction
endpackage

>>> rtl/ptz_ctrl.sv
// ----------------------------------------------------------------------------
// ptz_ctrl
// controller: takes an item, lets the datapath decide, then streams bytes
// ----------------------------------------------------------------------------
module ptz_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  ptz_pkg::t_sts i_sts,
    output ptz_pkg::t_ctl o_ctl
);
    import ptz_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DEC  = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_DEC;
            S_DEC: n_state = i_sts.send ? S_SEND : S_IDLE;
            S_SEND: if (i_out_ready && i_sts.last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_SEND);
    assign o_ctl.accept = (r_state == S_IDLE) && i_valid;
    assign o_ctl.load   = (r_state == S_DEC);
    assign o_ctl.step   = (r_state == S_SEND) && i_out_ready;
endmodule

>>> rtl/ptz_dp.sv
// ----------------------------------------------------------------------------
// ptz_dp
// datapath: link, tour and queue state, packet byte serializer
// ----------------------------------------------------------------------------
module ptz_dp #(
    parameter int TOUR_DEPTH  = ptz_pkg::TourDepthDef,
    parameter int QUEUE_DEPTH = ptz_pkg::QueueDepthDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    input  logic [4:0]    i_cmd,
    input  logic [7:0]    i_value,
    input  logic [7:0]    i_speed_value,
    input  logic [3:0]    i_list_position,
    input  ptz_pkg::t_ctl i_ctl,
    output ptz_pkg::t_sts o_sts,
    output logic [7:0]    o_packet_byte,
    output logic          o_last_byte
);
    import ptz_pkg::*;

    localparam int TW = $clog2(TOUR_DEPTH + 1);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int TI = (TOUR_DEPTH > 1) ? $clog2(TOUR_DEPTH) : 1;
    localparam int QI = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [15:0] r_dwell;
    logic        r_link, r_await, r_tour;
    logic [15:0] r_seq;
    logic [16:0] r_tick;
    logic [TW-1:0] r_tpos, r_tlen;
    logic [7:0]  r_tp [TOUR_DEPTH];
    t_entry      r_q [QUEUE_DEPTH];
    logic [QI-1:0] r_qh;
    logic [QW-1:0] r_qc;
    logic [4:0]  r_cmd, r_idx, r_len;
    logic [7:0]  r_val, r_spd;
    logic [3:0]  r_pos;
    t_entry      r_cur;

    // command decode, combinational on the captured item
    logic        enq, tick_fire;
    logic [7:0]  ea, eb, tsel, va255, sp255;
    logic [4:0]  ecode;
    logic [16:0] tick_inc;
    logic        pos_ok;
    logic [QW-1:0] cnt_after;
    logic        do_send;
    logic [15:0] seq_new;

    assign va255 = (r_val == 8'hff) ? 8'h00 : r_val;
    assign sp255 = (r_spd == 8'hff) ? 8'h00 : r_spd;
    assign tick_inc = r_tick + 17'd1;
    assign tick_fire = tick_inc >= {r_dwell, 1'b0};
    assign pos_ok = (32'(r_pos) < 32'(r_tlen));
    assign tsel = (r_cmd == C_START) ? r_tp[0] : r_tp[TI'(r_tpos)];
    assign seq_new = (r_cmd == C_LUP) ? 16'd1 : r_seq + 16'd1;

    always_comb begin
        enq = 1'b0; ecode = r_cmd; ea = 8'h00; eb = 8'h00;
        case (r_cmd)
            C_TICK: begin
                enq = r_tour && !r_await && tick_fire && (r_tpos < r_tlen);
                ecode = C_PCALL;
                ea = (tsel == 8'hff) ? 8'h00 : tsel;
            end
            C_START: begin
                enq = !r_tour && (r_tlen != '0);
                ecode = C_PCALL;
                ea = (tsel == 8'hff) ? 8'h00 : tsel;
            end
            C_LUP: enq = 1'b1;
            C_PSPD: begin enq = 1'b1; ea = va255; eb = sp255; end
            C_PSET, C_PCALL, C_PANL, C_PANR, C_TUP, C_TDN: begin
                enq = 1'b1; ea = va255;
            end
            C_ZIN, C_ZOUT, C_FIN, C_FOUT: begin enq = 1'b1; ea = {5'd0, r_val[2:0]}; end
            C_FMODE: begin enq = 1'b1; ea = {7'd0, r_val[0]}; end
            C_HOME, C_FSTOP, C_ZSTOP, C_MSTOP: enq = 1'b1;
            default: enq = 1'b0;
        endcase
    end

    // an item is enqueued only if the queue has room and the link is up
    logic link_n, q_ok, await_n;
    assign link_n = (r_cmd == C_LUP) ? 1'b1 : r_link;
    assign q_ok   = enq && link_n && (r_qc < QW'(QUEUE_DEPTH));
    assign cnt_after = r_qc + (q_ok ? QW'(1) : QW'(0));
    assign await_n = (r_cmd == C_REPLY) ? 1'b0 : r_await;
    assign do_send = ((r_cmd == C_REPLY) || q_ok) && link_n && !await_n &&
                     (cnt_after != '0) && (r_cmd != C_LDN) && (r_cmd != C_STOP);

    // tail slot, wrapped by one compare and subtract
    logic [QW:0]   wr_sum;
    logic [QI-1:0] wr_idx;
    assign wr_sum = (QW+1)'(r_qh) + (QW+1)'(r_qc);
    assign wr_idx = QI'((wr_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                        wr_sum - (QW+1)'(QUEUE_DEPTH) : wr_sum);
    t_entry new_e, head_e;
    assign new_e = '{b: eb, a: ea, code: ecode, seq: seq_new};
    assign head_e = (r_qc == '0) ? new_e : r_q[r_qh];

    // queue memory, tour list and byte serializer
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd <= i_cmd; r_val <= i_value; r_spd <= i_speed_value;
            r_pos <= i_list_position;
        end
        if (i_ctl.load && q_ok && !(do_send && r_qc == '0))
            r_q[wr_idx] <= new_e;
        if (i_ctl.load && do_send) begin
            r_cur <= head_e;
            r_idx <= 5'd0;
            r_len <= 5'(pay_len(head_e.code) + 8'd8);
        end else if (i_ctl.step) begin
            r_idx <= r_idx + 5'd1;
        end
        if (i_ctl.load) begin
            if (r_cmd == C_APPEND && r_tlen < TW'(TOUR_DEPTH))
                r_tp[TI'(r_tlen)] <= r_val;
            if (r_cmd == C_REPL && pos_ok)
                r_tp[TI'(r_pos)] <= r_val;
            if (r_cmd == C_REMOVE && pos_ok)
                for (int j = 0; j < TOUR_DEPTH - 1; j++)
                    if (j >= int'(r_pos)) r_tp[j] <= r_tp[j+1];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dwell <= '0; r_link <= 1'b0; r_await <= 1'b0; r_tour <= 1'b0;
            r_seq <= '0; r_tick <= '0; r_tpos <= '0; r_tlen <= '0;
            r_qh <= '0; r_qc <= '0;
        end else begin
            if (i_cfg_we) r_dwell <= i_cfg_data;
            if (i_ctl.load) begin
                if (enq) r_seq <= seq_new;
                r_link <= link_n && (r_cmd != C_LDN);
                r_await <= do_send ? 1'b1 : await_n;
                if (do_send) begin
                    r_qc <= cnt_after - QW'(1);
                    if (r_qc != '0)
                        r_qh <= (r_qh == QI'(QUEUE_DEPTH - 1)) ? '0 : r_qh + QI'(1);
                end else begin
                    r_qc <= cnt_after;
                end
                case (r_cmd)
                    C_TICK: if (r_tour && !r_await) begin
                        r_tick <= tick_fire ? 17'd0 : tick_inc;
                        if (tick_fire)
                            r_tpos <= (r_tpos < r_tlen && r_tpos + TW'(1) < r_tlen) ?
                                      r_tpos + TW'(1) : '0;
                    end
                    C_START: if (!r_tour) begin
                        r_tour <= 1'b1; r_tick <= '0; r_tpos <= TW'(1);
                    end
                    C_STOP, C_LDN: begin r_tour <= 1'b0; r_qc <= '0; end
                    C_APPEND: if (r_tlen < TW'(TOUR_DEPTH)) r_tlen <= r_tlen + TW'(1);
                    C_REMOVE: if (pos_ok) r_tlen <= r_tlen - TW'(1);
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.send    = do_send;
    assign o_sts.last    = (r_idx + 5'd1 == r_len);
    assign o_packet_byte = pkt_byte(r_cur, r_idx);
    assign o_last_byte   = o_sts.last;
endmodule

>>> rtl/ptz_command_framer_tour.sv
// ----------------------------------------------------------------------------
// ptz_command_framer_tour
// camera ptz command framer with queue and preset tour
// ----------------------------------------------------------------------------
// channel  | signals                                   | dir
// input    | i_valid/o_ready, i_cmd, i_value, ...      | in
// output   | o_valid/i_ready, o_packet_byte, o_last_byte | out
// config   | i_cfg_we, i_cfg_data (dwell_seconds)      | in
// an item is accepted, then decoded; a packet of up to 17 bytes may then follow,
// walked by the byte serializer one byte a cycle while the output is ready.
// output stalls hold the serializer; no new item is taken until the last byte.
// synchronous active-low reset, no clearing pass.
`include "ptz_command_framer_tour_defines.svh"
module ptz_command_framer_tour #(
    parameter int TOUR_DEPTH  = ptz_pkg::TourDepthDef,
    parameter int QUEUE_DEPTH = ptz_pkg::QueueDepthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_cmd,
    input  logic [7:0]  i_value,
    input  logic [7:0]  i_speed_value,
    input  logic [3:0]  i_list_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_packet_byte,
    output logic        o_last_byte
);
    import ptz_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // controller
    ptz_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_out_ready(i_ready), .o_out_valid(o_valid), .i_sts(sts), .o_ctl(ctl)
    );

    // datapath
    ptz_dp #(.TOUR_DEPTH(TOUR_DEPTH), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_cmd(i_cmd), .i_value(i_value), .i_speed_value(i_speed_value),
        .i_list_position(i_list_position), .i_ctl(ctl), .o_sts(sts),
        .o_packet_byte(o_packet_byte), .o_last_byte(o_last_byte)
    );

    // no item taken while bytes stream
    `PTZ_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    // after the last byte the block is idle again
    `PTZ_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_valid && i_ready && o_last_byte, o_ready)
endmodule
